// File: design/nearest_upsample_scatter_defines.svh
// Assertion helpers used by the datapath.
`ifndef NEAREST_UPSAMPLE_SCATTER_DEFINES_SVH
`define NEAREST_UPSAMPLE_SCATTER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define NUS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Next-cycle implication, checked outside reset
`define NUS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

// File: design/nus_pkg.sv
package nus_pkg;

    // Fixed field and counter widths
    localparam int unsigned PIX_W    = 32;
    localparam int unsigned OADDR_W  = 32;
    localparam int unsigned CNT_W    = 12;
    localparam int unsigned CFG_W    = 13;
    localparam int unsigned STR_W    = 4;
    localparam int unsigned APB_A_W  = 4;
    localparam int unsigned APB_D_W  = 32;

    // Register map (word index)
    localparam logic [1:0] REG_STRIDE = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Register reset values and fixed height limit
    localparam logic [STR_W-1:0] STRIDE_RST   = 4'd2;
    localparam logic [CFG_W-1:0] WIDTH_RST    = 13'd16;
    localparam logic [CFG_W-1:0] HEIGHT_RST   = 13'd16;
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 13'd4096;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             first;
    } t_in_item;

    typedef struct packed {
        logic [OADDR_W-1:0] out_addr;
        logic [PIX_W-1:0]   out_pixel;
        logic               last;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic base;
        logic emit;
        logic advance;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic last_copy;
    } t_sts;

endpackage

// File: design/nus_regs.sv
module nus_regs import nus_pkg::*; #(
    parameter int unsigned MAX_STRIDE = 8,
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned SW         = 4,
    parameter int unsigned WW         = 13
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_A_W-1:0] paddr,
    input  logic [APB_D_W-1:0] pwdata,
    output logic [APB_D_W-1:0] prdata,
    output logic               pready,
    output logic [SW-1:0]      o_stride,
    output logic [WW-1:0]      o_width,
    output logic [CFG_W-1:0]   o_height
);

    logic [STR_W-1:0] r_stride;
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [1:0]       idx;
    logic             wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (wr_en) begin
            if (idx == REG_STRIDE) r_stride <= pwdata[STR_W-1:0];
            if (idx == REG_WIDTH)  r_width  <= pwdata[CFG_W-1:0];
            if (idx == REG_HEIGHT) r_height <= pwdata[CFG_W-1:0];
        end
    end

    // Read mux
    always_comb begin
        unique case (idx)
            REG_STRIDE: prdata = APB_D_W'(r_stride);
            REG_WIDTH:  prdata = APB_D_W'(r_width);
            REG_HEIGHT: prdata = APB_D_W'(r_height);
            default:    prdata = '0;
        endcase
    end

    // Effective geometry: zero acts as one, large values saturate
    always_comb begin
        if (r_stride == '0)
            o_stride = SW'(1);
        else if (32'(r_stride) > MAX_STRIDE)
            o_stride = SW'(MAX_STRIDE);
        else
            o_stride = SW'(r_stride);

        if (r_width == '0)
            o_width = WW'(1);
        else if (32'(r_width) > MAX_WIDTH)
            o_width = WW'(MAX_WIDTH);
        else
            o_width = WW'(r_width);

        if (r_height == '0)
            o_height = CFG_W'(1);
        else if (r_height > HEIGHT_LIMIT)
            o_height = HEIGHT_LIMIT;
        else
            o_height = r_height;
    end

endmodule

// File: design/nus_ctrl.sv
module nus_ctrl import nus_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_MUL2 = 3'd2;
    localparam logic [2:0] ST_BASE = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall = (r_state != ST_IDLE);

    // Commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.mul1    = (r_state == ST_MUL1);
        o_cmd.mul2    = (r_state == ST_MUL2);
        o_cmd.base    = (r_state == ST_BASE);
        o_cmd.emit    = (r_state == ST_EMIT) && i_sts.out_free;
        o_cmd.advance = o_cmd.emit && i_sts.last_copy;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_BASE;
            ST_BASE: n_state = ST_EMIT;
            ST_EMIT: if (i_sts.out_free && i_sts.last_copy) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/nus_dpath.sv
`include "nearest_upsample_scatter_defines.svh"

module nus_dpath import nus_pkg::*; #(
    parameter int unsigned SW = 4,
    parameter int unsigned WW = 13,
    parameter int unsigned AW = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  t_in_item         i_in,
    input  logic [SW-1:0]    i_s,
    input  logic [WW-1:0]    i_w,
    input  logic [CFG_W-1:0] i_h,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output t_out_item        o_out
);

    localparam int unsigned RSW = CNT_W + SW;
    localparam int unsigned OWW = WW + SW;
    localparam int unsigned HSW = CFG_W + SW;
    localparam int unsigned PW1 = RSW + OWW;
    localparam int unsigned PW2 = OWW + HSW;

    // Position state
    logic [CNT_W-1:0] r_col, r_row;
    logic [CNT_W-1:0] n_col, n_row;
    logic [AW-1:0]    r_plane, n_plane;
    logic [CNT_W-1:0] col_inc, row_inc;

    // Per-item working registers
    logic [PIX_W-1:0] r_pixel;
    logic [RSW-1:0]   r_rs, r_cs;
    logic [OWW-1:0]   r_outw;
    logic [HSW-1:0]   r_hs;
    logic [AW-1:0]    r_rowoff, r_pstep;
    logic [AW-1:0]    r_row_addr, r_addr;
    logic [SW-1:0]    r_i, r_j;
    logic             row_end, last_copy;

    // Output register
    logic             r_out_valid;
    t_out_item        r_out;

    assign row_end   = (r_j == i_s - SW'(1));
    assign last_copy = row_end && (r_i == i_s - SW'(1));

    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_sts.last_copy = last_copy;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

    // Column / row / plane: cleared on a first pixel, advanced after the last copy
    always_comb begin
        col_inc = r_col + CNT_W'(1);
        row_inc = r_row + CNT_W'(1);
        n_col   = r_col;
        n_row   = r_row;
        n_plane = r_plane;
        if (i_cmd.load && i_in.first) begin
            n_col   = '0;
            n_row   = '0;
            n_plane = '0;
        end else if (i_cmd.advance) begin
            n_col = col_inc;
            if (32'(col_inc) >= 32'(i_w) || col_inc == '0) begin
                n_col = '0;
                n_row = row_inc;
                if (32'(row_inc) >= 32'(i_h) || row_inc == '0) begin
                    n_row   = '0;
                    n_plane = r_plane + r_pstep;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_plane <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_plane <= n_plane;
        end
    end

    // Address setup: products, then the second products, then the run base; addresses then step per emitted copy
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pixel <= i_in.pixel;
        end
        if (i_cmd.mul1) begin
            r_rs   <= RSW'(r_row) * RSW'(i_s);
            r_cs   <= RSW'(r_col) * RSW'(i_s);
            r_outw <= OWW'(i_w) * OWW'(i_s);
            r_hs   <= HSW'(i_h) * HSW'(i_s);
        end
        if (i_cmd.mul2) begin
            r_rowoff <= AW'(PW1'(r_rs) * PW1'(r_outw));
            r_pstep  <= AW'(PW2'(r_outw) * PW2'(r_hs));
        end
        if (i_cmd.base) begin
            r_row_addr <= r_plane + r_rowoff + AW'(r_cs);
            r_addr     <= r_plane + r_rowoff + AW'(r_cs);
            r_i        <= '0;
            r_j        <= '0;
        end else if (i_cmd.emit) begin
            if (row_end) begin
                r_j        <= '0;
                r_i        <= r_i + SW'(1);
                r_row_addr <= r_row_addr + AW'(r_outw);
                r_addr     <= r_row_addr + AW'(r_outw);
            end else begin
                r_j    <= r_j + SW'(1);
                r_addr <= r_addr + AW'(1);
            end
        end
    end

    // Output transaction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_addr  <= OADDR_W'(r_addr);
            r_out.out_pixel <= r_pixel;
            r_out.last      <= last_copy;
        end
    end

    // Checks
    `NUS_ASSERT_IMPL(a_emit_slot_free, i_cmd.emit, !r_out_valid || !i_out_stall)
    `NUS_ASSERT_NEXT(a_first_clears, i_cmd.load && i_in.first, {r_col, r_row, r_plane} == '0)
    `NUS_ASSERT_IMPL(a_copy_in_range, i_cmd.emit, r_i < i_s && r_j < i_s)

endmodule

// File: design/nearest_upsample_scatter.sv
// Each pixel passes three address setup steps (MUL1, MUL2, BASE) before its stride*stride
// copies are emitted, and a new input pixel is taken only once the last copy of the previous
// one is out. Copies leave the output register at one output word per cycle while not stalled.
// Reset (synchronous, active low): column, row and plane base go to zero,
// stride to 2, width and height to 16; the output register is emptied.
module nearest_upsample_scatter import nus_pkg::*; #(
    parameter int unsigned MAX_STRIDE = 8,
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned ADDR_BITS  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_A_W-1:0] paddr,
    input  logic [APB_D_W-1:0] pwdata,
    output logic [APB_D_W-1:0] prdata,
    output logic               pready
);

    localparam int unsigned SW = $clog2(MAX_STRIDE + 1);
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

    logic [SW-1:0]    eff_s;
    logic [WW-1:0]    eff_w;
    logic [CFG_W-1:0] eff_h;
    t_cmd             cmd;
    t_sts             sts;

    nus_regs #(
        .MAX_STRIDE (MAX_STRIDE),
        .MAX_WIDTH  (MAX_WIDTH),
        .SW         (SW),
        .WW         (WW)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_stride (eff_s),
        .o_width  (eff_w),
        .o_height (eff_h)
    );

    nus_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    nus_dpath #(
        .SW (SW),
        .WW (WW),
        .AW (ADDR_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .i_s         (eff_s),
        .i_w         (eff_w),
        .i_h         (eff_h),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// File: tb/sv/tb_nearest_upsample_scatter.sv
`timescale 1ns / 100ps

module tb_nearest_upsample_scatter;
    import nus_pkg::*;

    localparam int unsigned STRIDE_CAP   = 8;
    localparam int unsigned WIDTH_CAP    = 4096;
    localparam int          CYCLE_LIMIT  = 3000000;
    localparam int          RANDOM_ITEMS = 230;
    localparam int          DRAIN_CYCLES = 16;

    // One line of the directed plan: either a register write or one pixel
    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  reg_idx;
        logic [31:0] wdata;
        t_in_item    item;
        logic        typed;
        logic [31:0] typed_addr;
    } t_plan_row;

    // Travels with each pixel sent: a typed-in address replaces the prediction
    typedef struct packed {
        logic        typed;
        logic [31:0] addr;
    } t_pixel_tag;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    t_in_item            in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out_item           out_item;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_A_W-1:0]  paddr = '0;
    logic [APB_D_W-1:0]  pwdata = '0;
    logic [APB_D_W-1:0]  prdata;
    logic                pready;

    // Register shadows and scatter state
    logic [STR_W-1:0]    cfg_stride = STRIDE_RST;
    logic [CFG_W-1:0]    cfg_width = WIDTH_RST;
    logic [CFG_W-1:0]    cfg_height = HEIGHT_RST;
    logic [CNT_W-1:0]    up_col = '0;
    logic [CNT_W-1:0]    up_row = '0;
    logic [31:0]         up_base = '0;

    t_out_item           pending_copies[$];
    t_pixel_tag          pixel_tags[$];
    t_plan_row           dir_plan[$];

    int                  fail_count = 0;
    int                  cycle_count = 0;
    int                  stall_left = 0;
    bit                  gap_mode = 1'b0;
    bit                  stall_mode = 1'b0;

    nearest_upsample_scatter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // Append one line to the directed plan
    function automatic void plan_row(logic is_cfg, logic [1:0] idx, logic [31:0] wdata,
                                     logic [31:0] pixel, logic first, logic typed,
                                     logic [31:0] addr);
        dir_plan = {dir_plan, t_plan_row'{is_cfg, idx, wdata, t_in_item'{pixel, first},
                                          typed, addr}};
    endfunction

    // Expected copies of one pixel, then advance column, row and plane
    function automatic void scatter_pixel(t_in_item it, bit keep);
        logic [31:0] s;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] out_w;
        logic [31:0] row_addr;
        t_out_item   copy;
        s = (cfg_stride == 0) ? 32'd1 :
            (cfg_stride > STRIDE_CAP) ? STRIDE_CAP : {28'd0, cfg_stride};
        w = (cfg_width == 0) ? 32'd1 :
            (cfg_width > WIDTH_CAP) ? WIDTH_CAP : {19'd0, cfg_width};
        h = (cfg_height == 0) ? 32'd1 :
            (cfg_height > HEIGHT_LIMIT) ? {19'd0, HEIGHT_LIMIT} : {19'd0, cfg_height};
        out_w = w * s;
        if (it.first) begin
            up_col = '0;
            up_row = '0;
            up_base = '0;
        end
        for (int unsigned i = 0; i < s; i++) begin
            row_addr = up_base + ({20'd0, up_row} * s + i) * out_w + {20'd0, up_col} * s;
            for (int unsigned j = 0; j < s; j++) begin
                copy.out_addr  = row_addr + j;
                copy.out_pixel = it.pixel;
                copy.last      = (i == s - 1) && (j == s - 1);
                if (keep)
                    pending_copies = {pending_copies, copy};
            end
        end
        up_col = up_col + 1'b1;
        if ({20'd0, up_col} >= w || up_col == 0) begin
            up_col = '0;
            up_row = up_row + 1'b1;
            if ({20'd0, up_row} >= h || up_row == 0) begin
                up_row = '0;
                up_base = up_base + out_w * h * s;
            end
        end
    endfunction

    // Input acceptance feeds the predictor; output acceptance is checked
    always @(posedge clk) begin
        t_pixel_tag tag;
        t_out_item  want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                tag = pixel_tags.pop_front();
                scatter_pixel(in_item, !tag.typed);
                if (tag.typed)
                    pending_copies = {pending_copies,
                                      t_out_item'{tag.addr, in_item.pixel, 1'b1}};
            end
            if (out_valid && !out_stall) begin
                if (pending_copies.size() == 0) begin
                    report_mismatch("unexpected copy, addr", out_item.out_addr, '0);
                end else begin
                    want = pending_copies.pop_front();
                    if (out_item.out_addr !== want.out_addr)
                        report_mismatch("out_addr", out_item.out_addr, want.out_addr);
                    if (out_item.out_pixel !== want.out_pixel)
                        report_mismatch("out_pixel", out_item.out_pixel, want.out_pixel);
                    if (out_item.last !== want.last)
                        report_mismatch("last", {31'd0, out_item.last}, {31'd0, want.last});
                end
            end
        end
    end

    // Output back-pressure in random bursts while stall mode is on
    always @(posedge clk) begin
        if (stall_left == 0 && stall_mode && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 15);
        if (stall_left != 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Send one pixel, with an optional gap before it
    task automatic push_pixel(t_in_item it, logic typed, logic [31:0] typed_addr);
        int gap;
        if (gap_mode && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_tags = {pixel_tags, t_pixel_tag'{typed, typed_addr}};
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    // Wait until every expected copy is out and the block has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_copies.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // APB write: setup, access, then back to idle
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_STRIDE: cfg_stride = data[STR_W-1:0];
            REG_WIDTH:  cfg_width  = data[CFG_W-1:0];
            REG_HEIGHT: cfg_height = data[CFG_W-1:0];
            default: ;
        endcase
    endtask

    // Bring the column and row to given values at stride 1, then close the plane
    task automatic fill_plane(int unsigned width, int unsigned height, bit restart);
        settle();
        write_reg(REG_STRIDE, 32'd1);
        write_reg(REG_WIDTH, 32'd1);
        write_reg(REG_HEIGHT, height);
        for (int q = 0; q < height - 1; q++)
            push_pixel('{$urandom(), restart && q == 0}, 1'b0, '0);
        settle();
        write_reg(REG_WIDTH, width);
        repeat (width - 1) push_pixel('{$urandom(), 1'b0}, 1'b0, '0);
        settle();
        write_reg(REG_STRIDE, STRIDE_CAP);
        push_pixel('{$urandom(), 1'b0}, 1'b0, '0);
    endtask

    initial begin
        int          sent;
        int          run;
        logic [31:0] val;
        bit          calm;

        // Directed plan; typed rows run at stride 1 so one copy is expected
        //       cfg   reg         wdata          pixel          first typed addr
        plan_row(1'b0, REG_STRIDE, 32'd0,         32'h0000_0000, 1'b1, 1'b0, 32'd0);
        plan_row(1'b0, REG_STRIDE, 32'd0,         32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0);
        // stride one, zero width and height acting as one; upper bits are ignored
        plan_row(1'b1, REG_STRIDE, 32'hFFFF_FFF1, 32'd0,         1'b0, 1'b0, 32'd0);
        plan_row(1'b1, REG_WIDTH,  32'hFFFF_E000, 32'd0,         1'b0, 1'b0, 32'd0);
        plan_row(1'b1, REG_HEIGHT, 32'h0000_E000, 32'd0,         1'b0, 1'b0, 32'd0);
        plan_row(1'b0, REG_STRIDE, 32'd0,         32'hA5A5_A5A5, 1'b1, 1'b1, 32'd0);
        plan_row(1'b0, REG_STRIDE, 32'd0,         32'h5A5A_5A5A, 1'b0, 1'b1, 32'd1);
        plan_row(1'b1, REG_STRIDE, 32'hABCD_EF00, 32'd0,         1'b0, 1'b0, 32'd0);
        plan_row(1'b0, REG_STRIDE, 32'd0,         32'h1234_5678, 1'b0, 1'b1, 32'd2);
        // 3 x 2 plane at stride 1
        plan_row(1'b1, REG_WIDTH,  32'd3,         32'd0,         1'b0, 1'b0, 32'd0);
        plan_row(1'b1, REG_HEIGHT, 32'd2,         32'd0,         1'b0, 1'b0, 32'd0);
        plan_row(1'b0, REG_STRIDE, 32'd0,         32'h0000_0001, 1'b1, 1'b1, 32'd0);
        plan_row(1'b0, REG_STRIDE, 32'd0,         32'h0000_0002, 1'b0, 1'b1, 32'd1);
        plan_row(1'b0, REG_STRIDE, 32'd0,         32'h0000_0004, 1'b0, 1'b1, 32'd2);
        plan_row(1'b0, REG_STRIDE, 32'd0,         32'h0000_0008, 1'b0, 1'b1, 32'd3);
        plan_row(1'b0, REG_STRIDE, 32'd0,         32'h0000_0010, 1'b0, 1'b1, 32'd4);
        // width shrinks under a column already at the new limit
        plan_row(1'b1, REG_WIDTH,  32'd2,         32'd0,         1'b0, 1'b0, 32'd0);
        plan_row(1'b0, REG_STRIDE, 32'd0,         32'h0000_0020, 1'b0, 1'b1, 32'd4);
        plan_row(1'b0, REG_STRIDE, 32'd0,         32'h0000_0040, 1'b0, 1'b1, 32'd4);
        // saturating stride, width and height
        plan_row(1'b1, REG_STRIDE, 32'h0000_000F, 32'd0,         1'b0, 1'b0, 32'd0);
        plan_row(1'b1, REG_WIDTH,  32'h0000_1FFF, 32'd0,         1'b0, 1'b0, 32'd0);
        plan_row(1'b1, REG_HEIGHT, 32'hFFFF_FFFF, 32'd0,         1'b0, 1'b0, 32'd0);
        plan_row(1'b0, REG_STRIDE, 32'd0,         32'hFFFF_0000, 1'b1, 1'b0, 32'd0);
        plan_row(1'b0, REG_STRIDE, 32'd0,         32'h0000_FFFF, 1'b0, 1'b0, 32'd0);
        // exact maxima
        plan_row(1'b1, REG_STRIDE, 32'd8,         32'd0,         1'b0, 1'b0, 32'd0);
        plan_row(1'b1, REG_WIDTH,  32'd4096,      32'd0,         1'b0, 1'b0, 32'd0);
        plan_row(1'b1, REG_HEIGHT, 32'd4096,      32'd0,         1'b0, 1'b0, 32'd0);
        plan_row(1'b0, REG_STRIDE, 32'd0,         32'h8000_0001, 1'b0, 1'b0, 32'd0);
        plan_row(1'b0, REG_STRIDE, 32'd0,         32'h7FFF_FFFE, 1'b1, 1'b0, 32'd0);

        // Reset
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_plan[k]) begin
            if (dir_plan[k].is_cfg) begin
                settle();
                write_reg(dir_plan[k].reg_idx, dir_plan[k].wdata);
            end else begin
                push_pixel(dir_plan[k].item, dir_plan[k].typed, dir_plan[k].typed_addr);
            end
        end

        // Geometry grown under counters at their limits closes the plane at stride 8
        fill_plane(8, 4, 1'b1);

        // Random segments: new geometry, then mostly well-formed runs
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            calm = (sent >= RANDOM_ITEMS - 40);
            gap_mode = !calm && $urandom_range(0, 2) != 0;
            stall_mode = !calm && $urandom_range(0, 2) != 0;
            case ($urandom_range(0, 9))
                0:       val = 32'd0;
                1:       val = $urandom_range(STRIDE_CAP + 1, 15);
                2:       val = STRIDE_CAP;
                default: val = $urandom_range(1, 3);
            endcase
            write_reg(REG_STRIDE, ($urandom() & 32'hFFFF_FFF0) | val);
            case ($urandom_range(0, 9))
                0:       val = 32'd0;
                1:       val = $urandom_range(WIDTH_CAP + 1, 8191);
                2:       val = WIDTH_CAP;
                3:       val = $urandom_range(1, WIDTH_CAP);
                default: val = $urandom_range(1, 5);
            endcase
            write_reg(REG_WIDTH, ($urandom() & 32'hFFFF_E000) | val);
            case ($urandom_range(0, 9))
                0:       val = 32'd0;
                1:       val = $urandom_range(HEIGHT_LIMIT + 1, 8191);
                2:       val = HEIGHT_LIMIT;
                3:       val = $urandom_range(1, HEIGHT_LIMIT);
                default: val = $urandom_range(1, 4);
            endcase
            write_reg(REG_HEIGHT, ($urandom() & 32'hFFFF_E000) | val);
            run = $urandom_range(15, 40);
            for (int q = 0; q < run; q++) begin
                push_pixel('{$urandom(),
                             (q == 0 && $urandom_range(0, 3) != 0) ||
                             $urandom_range(0, 19) == 0}, 1'b0, '0);
                sent++;
            end
        end

        // Drain
        gap_mode = 1'b0;
        stall_mode = 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
